// ===== src/assert_macros.svh =====
// Assertion macros used by the normaliser top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion on a clock with asynchronous active-low reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m failed");
// Condition that must never hold
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("%m failed");
`endif

// ===== src/bbn_pkg.sv =====
// Package: types, constants and codes for the bounding-box normaliser
package bbn_pkg;
  localparam int unsigned MaxVertices = 4096;
  localparam int unsigned AddrW = $clog2(MaxVertices);
  localparam int unsigned CntW = AddrW + 1;
  localparam int unsigned QuotW = 17;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_FETCH = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic               entry_valid;
    logic               final_entry;
    logic               degenerate;
  } out_word_t;

  // Fetch job handed from front to back
  typedef struct packed {
    logic               entry_valid;
    logic               final_entry;
    logic               degenerate;
    logic [AddrW-1:0]   addr;
    logic [32:0]        span;
    logic signed [33:0] sum_x;
    logic signed [33:0] sum_y;
    logic signed [33:0] sum_z;
  } job_t;
endpackage

// ===== src/bbox_unit_normalizer_top.sv =====
// Top level of the bounding-box unit-cube normaliser
// channel | handshake          | word
// in      | in_valid_i/ready_o | bbn_pkg::in_word_t  (mode, coord_x/y/z)
// out     | out_valid_o/ready_i| bbn_pkg::out_word_t (norm_x/y/z, flags)
// A load is taken while the job queue has room; a clear waits until no fetch is in flight.
// A fetch word is taken while the job queue has room; its job passes the front
// job register and the queue to the back end, which does one RAM read, then runs
// a one-bit-a-cycle restoring divider shared by the three axes (per axis: setup,
// shifts, round). The back end takes a new fetch once its last word is accepted.
// Reset (rst_ni low) clears counts, bounds and all handshake state at once.
// The job queue lets loads continue while the divider is busy.
`include "assert_macros.svh"
module bbox_unit_normalizer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bbn_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bbn_pkg::out_word_t out_word_o
);
  import bbn_pkg::*;
  logic fj_valid, fj_ready, qj_valid, qj_ready;
  logic pipe_idle;
  logic flags_bad;
  job_t fj, qj;
  logic [AddrW-1:0] rd_addr;
  logic signed [31:0] rx, ry, rz;

  // no job waiting in front or queue, back end idle with no finished word waiting
  assign pipe_idle = !fj_valid && !qj_valid && qj_ready;

  // Front holds a clear back until no fetch is in flight, so later loads cannot
  // overwrite a vertex the back end has still to read
  bbn_front u_front (
    .clk_i, .rst_ni, .valid_i(in_valid_i), .ready_o(in_ready_o), .word_i(in_word_i),
    .idle_i(pipe_idle),
    .job_valid_o(fj_valid), .job_ready_i(fj_ready), .job_o(fj),
    .rd_addr_i(rd_addr), .rd_x_o(rx), .rd_y_o(ry), .rd_z_o(rz)
  );
  bbn_queue u_queue (
    .clk_i, .rst_ni, .valid_i(fj_valid), .ready_o(fj_ready), .data_i(fj),
    .valid_o(qj_valid), .ready_i(qj_ready), .data_o(qj)
  );
  bbn_back u_back (
    .clk_i, .rst_ni, .job_valid_i(qj_valid), .job_ready_o(qj_ready), .job_i(qj),
    .rd_addr_o(rd_addr), .rd_x_i(rx), .rd_y_i(ry), .rd_z_i(rz),
    .valid_o(out_valid_o), .ready_i(out_ready_i), .word_o(out_word_o)
  );

  // past-end word carries no flags
  assign flags_bad = !out_word_o.entry_valid &&
                     (out_word_o.final_entry || out_word_o.degenerate);

  `ASSERT_NEVER(a_flags, clk_i, rst_ni, out_valid_o && flags_bad)
  `ASSERT_CLK(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)
endmodule

// ===== src/bbn_front.sv =====
// Front end: stores vertices, tracks the bounding box, issues fetch jobs
module bbn_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  bbn_pkg::in_word_t    word_i,
  input  logic                 idle_i,
  output logic                 job_valid_o,
  input  logic                 job_ready_i,
  output bbn_pkg::job_t        job_o,
  input  logic [bbn_pkg::AddrW-1:0] rd_addr_i,
  output logic signed [31:0]   rd_x_o,
  output logic signed [31:0]   rd_y_o,
  output logic signed [31:0]   rd_z_o
);
  import bbn_pkg::*;

  logic [95:0] mem_q [MaxVertices];
  logic [95:0] rd_q;
  logic [CntW-1:0] count_q, count_d, rptr_q, rptr_d;
  logic signed [31:0] min_q [3], max_q [3], min_d [3], max_d [3];
  logic started_q, started_d;
  logic fire, do_load;
  logic signed [31:0] c [3];
  logic signed [32:0] diff [3];
  logic [32:0] span;
  job_t job;

  // a clear waits until no fetch is in flight, so reloads cannot overwrite unread vertices
  assign ready_o = job_ready_i && (word_i.mode != MODE_CLEAR || idle_i);
  assign fire = valid_i && ready_o;
  assign do_load = fire && word_i.mode == MODE_LOAD && count_q != CntW'(MaxVertices);
  assign c[0] = word_i.coord_x;
  assign c[1] = word_i.coord_y;
  assign c[2] = word_i.coord_z;

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      mem_q[count_q[AddrW-1:0]] <= {word_i.coord_x, word_i.coord_y, word_i.coord_z};
    end
    rd_q <= mem_q[rd_addr_i];
  end
  assign rd_x_o = rd_q[95:64];
  assign rd_y_o = rd_q[63:32];
  assign rd_z_o = rd_q[31:0];

  always_comb begin
    count_d = count_q;
    rptr_d = rptr_q;
    started_d = started_q;
    for (int a = 0; a < 3; a++) begin
      min_d[a] = min_q[a];
      max_d[a] = max_q[a];
    end
    if (fire && word_i.mode == MODE_CLEAR) begin
      count_d = '0;
      rptr_d = '0;
      started_d = 1'b0;
      for (int a = 0; a < 3; a++) begin
        min_d[a] = '0;
        max_d[a] = '0;
      end
    end else if (do_load) begin
      count_d = count_q + 1'b1;
      started_d = 1'b1;
      for (int a = 0; a < 3; a++) begin
        if (!started_q || c[a] < min_q[a]) min_d[a] = c[a];
        if (!started_q || c[a] > max_q[a]) max_d[a] = c[a];
      end
    end else if (fire && word_i.mode == MODE_FETCH && rptr_q < count_q) begin
      rptr_d = rptr_q + 1'b1;
    end
  end

  always_comb begin
    span = '0;
    for (int a = 0; a < 3; a++) begin
      diff[a] = 33'(max_q[a]) - 33'(min_q[a]);
      if (diff[a] > $signed(span)) span = diff[a];
    end
    job.entry_valid = rptr_q < count_q;
    job.final_entry = job.entry_valid && (rptr_q + 1'b1 == count_q);
    job.degenerate = job.entry_valid && span == '0;
    job.addr = rptr_q[AddrW-1:0];
    job.span = span;
    job.sum_x = 34'(max_q[0]) + 34'(min_q[0]);
    job.sum_y = 34'(max_q[1]) + 34'(min_q[1]);
    job.sum_z = 34'(max_q[2]) + 34'(min_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rptr_q <= '0;
      started_q <= 1'b0;
      job_valid_o <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        min_q[a] <= '0;
        max_q[a] <= '0;
      end
    end else begin
      count_q <= count_d;
      rptr_q <= rptr_d;
      started_q <= started_d;
      for (int a = 0; a < 3; a++) begin
        min_q[a] <= min_d[a];
        max_q[a] <= max_d[a];
      end
      if (fire && word_i.mode == MODE_FETCH) job_valid_o <= 1'b1;
      else if (job_ready_i) job_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && word_i.mode == MODE_FETCH) job_o <= job;
  end
endmodule

// ===== src/bbn_queue.sv =====
// Two-entry job queue between front and back
module bbn_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  bbn_pkg::job_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output bbn_pkg::job_t data_o
);
  import bbn_pkg::*;
  job_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign push = valid_i && ready_o;
  assign pop = valid_o && ready_i;
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= data_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== src/bbn_back.sv =====
// Back end: serial restoring divide of three axes, rounding and saturation
module bbn_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  output logic                 job_ready_o,
  input  bbn_pkg::job_t        job_i,
  output logic [bbn_pkg::AddrW-1:0] rd_addr_o,
  input  logic signed [31:0]   rd_x_i,
  input  logic signed [31:0]   rd_y_i,
  input  logic signed [31:0]   rd_z_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output bbn_pkg::out_word_t   word_o
);
  import bbn_pkg::*;
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StLoad = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0] st_q;
  job_t job_q;
  logic [1:0] axis_q;
  logic [33:0] rem_q;
  logic [QuotW-1:0] quo_q;
  logic neg_q;
  logic signed [15:0] res_q [3];
  logic signed [31:0] v_q [3];
  logic signed [34:0] num;
  logic [QuotW-1:0] qr;
  logic signed [15:0] sat;
  logic signed [33:0] sum_sel;

  // Quotient of 2^16*mag / span, last bit gives rounding (half up)
  assign rd_addr_o = job_q.addr;
  assign job_ready_o = st_q == StIdle && !valid_o;

  always_comb begin
    unique case (axis_q)
      2'd0: sum_sel = job_q.sum_x;
      2'd1: sum_sel = job_q.sum_y;
      default: sum_sel = job_q.sum_z;
    endcase
    num = 35'(v_q[axis_q]) * 35'sd2 - 35'(sum_sel);
    qr = (quo_q >> 1) + QuotW'(quo_q[0]);
    if (neg_q) sat = (qr > QuotW'(32768)) ? -16'sd32768 : -$signed(qr[15:0]);
    else sat = (qr > QuotW'(32767)) ? 16'sd32767 : $signed(qr[15:0]);
  end

  // Long division: dividend is mag << 15 (50 bits), one further step gives mag << 16
  // over span; low 17 quotient bits are enough once larger quotients saturate.
  logic big_q;
  logic [6:0] step_q;
  logic [49:0] dvd_q;
  logic [33:0] r_next;
  logic [33:0] r_sh;
  assign r_sh = {rem_q[32:0], dvd_q[49]};
  assign r_next = r_sh - {1'b0, job_q.span};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      valid_o <= 1'b0;
    end else begin
      if (valid_o && ready_i) valid_o <= 1'b0;
      unique case (st_q)
        StIdle: if (job_valid_i && job_ready_o) begin
          job_q <= job_i;
          st_q <= StRead;
        end
        StRead: st_q <= StLoad;
        StLoad: begin
          v_q[0] <= rd_x_i;
          v_q[1] <= rd_y_i;
          v_q[2] <= rd_z_i;
          axis_q <= 2'd0;
          if (!job_q.entry_valid || job_q.degenerate) begin
            for (int a = 0; a < 3; a++) res_q[a] <= '0;
            st_q <= StOut;
          end else begin
            st_q <= StDiv;
            step_q <= '0;
          end
        end
        StDiv: begin
          if (step_q == 7'd0) begin
            neg_q <= num < 0;
            dvd_q <= {(num < 0) ? 35'(-num) : 35'(num), 15'd0};
            rem_q <= '0;
            quo_q <= '0;
            big_q <= 1'b0;
            step_q <= 7'd1;
          end else begin
            dvd_q <= {dvd_q[48:0], 1'b0};
            if (!r_next[33]) begin
              rem_q <= r_next;
              quo_q <= {quo_q[QuotW-2:0], 1'b1};
              if (quo_q[QuotW-1]) big_q <= 1'b1;
            end else begin
              rem_q <= r_sh;
              quo_q <= {quo_q[QuotW-2:0], 1'b0};
              if (quo_q[QuotW-1]) big_q <= 1'b1;
            end
            if (step_q == 7'd51) begin
              step_q <= 7'd52;
            end else if (step_q == 7'd52) begin
              res_q[axis_q] <= big_q ? (neg_q ? -16'sd32768 : 16'sd32767) : sat;
              step_q <= '0;
              if (axis_q == 2'd2) st_q <= StOut;
              else axis_q <= axis_q + 2'd1;
            end else step_q <= step_q + 7'd1;
          end
        end
        StOut: begin
          word_o.norm_x <= res_q[0];
          word_o.norm_y <= res_q[1];
          word_o.norm_z <= res_q[2];
          word_o.entry_valid <= job_q.entry_valid;
          word_o.final_entry <= job_q.final_entry;
          word_o.degenerate <= job_q.degenerate;
          valid_o <= 1'b1;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the bounding-box unit-cube normaliser
`timescale 1ns / 100ps
module testbench;
  import bbn_pkg::*;

  localparam int unsigned StoreDepth = 4096;
  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned TailCycles = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_word_t out_word_o;

  bbox_unit_normalizer_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_word_o(out_word_o)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state: a shadow of the vertex store and the running box
  logic signed [31:0] shadow_vtx [StoreDepth][3];
  int unsigned shadow_count;
  int unsigned shadow_rd;
  logic signed [31:0] shadow_lo [3];
  logic signed [31:0] shadow_hi [3];
  bit shadow_started;

  out_word_t pending_words [$];
  int unsigned predicted_words = 0;
  int unsigned fail_count = 0;
  int unsigned word_count = 0;
  int unsigned fetch_words = 0;
  int unsigned degen_words = 0;
  int unsigned past_end_words = 0;
  int unsigned cycle_count = 0;

  // Sender and receiver pacing, in percent of idle cycles
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit recv_hold = 1'b0;

  function automatic logic signed [15:0] scale_axis(logic signed [31:0] v,
                                                    logic signed [31:0] lo,
                                                    logic signed [31:0] hi,
                                                    logic [32:0] span);
    logic signed [34:0] num;
    logic [34:0] mag;
    logic [63:0] quo;
    num = 35'(2 * 35'(v)) - 35'(hi) - 35'(lo);
    mag = (num < 0) ? 35'(-num) : 35'(num);
    // round half away from zero: (2*mag*2^15 + span) / (2*span)
    quo = ((64'(mag) << 16) + 64'(span)) / (64'(span) << 1);
    if (num < 0) return (quo > 64'd32768) ? -16'sd32768 : 16'(-64'(quo));
    return (quo > 64'd32767) ? 16'sd32767 : 16'(quo);
  endfunction

  // Updates the shadow state for one accepted word; queues any result
  task automatic model_word(input in_word_t w);
    out_word_t r;
    logic [32:0] span, d;
    logic signed [31:0] c [3];
    r = '0;
    case (mode_e'(w.mode))
      MODE_CLEAR: begin
        shadow_count = 0;
        shadow_rd = 0;
        shadow_started = 1'b0;
        for (int a = 0; a < 3; a++) begin
          shadow_lo[a] = '0;
          shadow_hi[a] = '0;
        end
      end
      MODE_LOAD: begin
        c[0] = w.coord_x;
        c[1] = w.coord_y;
        c[2] = w.coord_z;
        if (shadow_count < StoreDepth) begin
          for (int a = 0; a < 3; a++) begin
            shadow_vtx[shadow_count][a] = c[a];
            if (!shadow_started) begin
              shadow_lo[a] = c[a];
              shadow_hi[a] = c[a];
            end else begin
              if (c[a] < shadow_lo[a]) shadow_lo[a] = c[a];
              if (c[a] > shadow_hi[a]) shadow_hi[a] = c[a];
            end
          end
          shadow_started = 1'b1;
          shadow_count++;
        end
      end
      MODE_FETCH: begin
        if (shadow_rd < shadow_count) begin
          span = '0;
          for (int a = 0; a < 3; a++) begin
            d = 33'(33'(shadow_hi[a]) - 33'(shadow_lo[a]));
            if (d > span) span = d;
          end
          r.entry_valid = 1'b1;
          r.final_entry = (shadow_rd + 1 == shadow_count);
          if (span == 0) begin
            r.degenerate = 1'b1;
          end else begin
            r.norm_x = scale_axis(shadow_vtx[shadow_rd][0], shadow_lo[0], shadow_hi[0], span);
            r.norm_y = scale_axis(shadow_vtx[shadow_rd][1], shadow_lo[1], shadow_hi[1], span);
            r.norm_z = scale_axis(shadow_vtx[shadow_rd][2], shadow_lo[2], shadow_hi[2], span);
          end
          shadow_rd++;
        end
        pending_words.push_back(r);
        predicted_words++;
      end
      default: ;
    endcase
  endtask

  // Sends one word: optional idle gaps first, then hold valid until accepted
  task automatic send_word(input in_word_t w);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    model_word(w);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Directed word that carries its own typed-in expectation
  task automatic send_checked(input in_word_t w, input out_word_t want);
    int unsigned n;
    n = predicted_words;
    send_word(w);
    if (predicted_words != n + 1) begin
      $error("directed fetch gave no prediction");
      fail_count++;
    end else if (pending_words[$] != want) begin
      $error("predictor disagrees with typed-in word: exp %h act %h", want, pending_words[$]);
      fail_count++;
    end
  endtask

  function automatic in_word_t mk(mode_e m, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_word_t w;
    w.mode = m;
    w.coord_x = x;
    w.coord_y = y;
    w.coord_z = z;
    return w;
  endfunction

  function automatic out_word_t res(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                    logic ev, logic fe, logic dg);
    out_word_t r;
    r.norm_x = x;
    r.norm_y = y;
    r.norm_z = z;
    r.entry_valid = ev;
    r.final_entry = fe;
    r.degenerate = dg;
    return r;
  endfunction

  task automatic drain_results;
    while (pending_words.size() != 0) @(negedge clk_i);
  endtask

  // Receiver: ready is redrawn every falling edge
  always @(negedge clk_i) begin
    if (!rst_ni || recv_hold) out_ready_i <= 1'b0;
    else out_ready_i <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  // Result checker
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      word_count++;
      if (pending_words.size() == 0) begin
        $error("unexpected word %h", out_word_o);
        fail_count++;
      end else begin
        want = pending_words.pop_front();
        if (want.entry_valid) fetch_words++;
        else past_end_words++;
        if (want.degenerate) degen_words++;
        if (out_word_o.norm_x !== want.norm_x) begin
          $error("norm_x exp %0d act %0d", want.norm_x, out_word_o.norm_x);
          fail_count++;
        end
        if (out_word_o.norm_y !== want.norm_y) begin
          $error("norm_y exp %0d act %0d", want.norm_y, out_word_o.norm_y);
          fail_count++;
        end
        if (out_word_o.norm_z !== want.norm_z) begin
          $error("norm_z exp %0d act %0d", want.norm_z, out_word_o.norm_z);
          fail_count++;
        end
        if (out_word_o.entry_valid !== want.entry_valid) begin
          $error("entry_valid exp %0b act %0b", want.entry_valid, out_word_o.entry_valid);
          fail_count++;
        end
        if (out_word_o.final_entry !== want.final_entry) begin
          $error("final_entry exp %0b act %0b", want.final_entry, out_word_o.final_entry);
          fail_count++;
        end
        if (out_word_o.degenerate !== want.degenerate) begin
          $error("degenerate exp %0b act %0b", want.degenerate, out_word_o.degenerate);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Random coordinate: mostly modest Q16.16 values, sometimes full range
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  // One model: clear, a few loads, fetches past the end, some noise
  task automatic random_model(input int unsigned max_loads, inout int unsigned sent);
    int unsigned loads, fetches;
    logic [31:0] flat;
    bit flat_axis;
    loads = $urandom_range(max_loads, 1);
    fetches = loads + $urandom_range(2);
    flat_axis = ($urandom_range(5) == 0);
    flat = rand_coord();
    send_word(mk(MODE_CLEAR, $urandom(), $urandom(), $urandom()));
    sent++;
    for (int i = 0; i < loads; i++) begin
      if (flat_axis) send_word(mk(MODE_LOAD, flat, flat, flat));
      else send_word(mk(MODE_LOAD, rand_coord(), rand_coord(), rand_coord()));
      sent++;
      if ($urandom_range(7) == 0) begin
        send_word(mk(MODE_FETCH, $urandom(), $urandom(), $urandom()));
        sent++;
        fetches--;
      end
      if ($urandom_range(15) == 0) begin
        send_word(mk(MODE_NONE, $urandom(), $urandom(), $urandom()));
      end
    end
    for (int i = 0; i < int'(fetches); i++) begin
      send_word(mk(MODE_FETCH, $urandom(), $urandom(), $urandom()));
      sent++;
    end
  endtask

  typedef struct {
    in_word_t  stim;
    bit        typed;
    out_word_t want;
  } dir_row_t;

  initial begin
    dir_row_t rows [$];
    int unsigned sent;
    int unsigned phase_len;
    // Directed table: fetches whose answer is plain are typed in
    rows = '{
      '{mk(MODE_FETCH, 0, 0, 0), 1, res(0, 0, 0, 0, 0, 0)},
      '{mk(MODE_NONE, '1, '1, '1), 0, '0},
      '{mk(MODE_LOAD, 32'h0001_0000, 32'hffff_0000, 0), 0, '0},
      '{mk(MODE_FETCH, 0, 0, 0), 1, res(0, 0, 0, 1, 1, 1)},
      '{mk(MODE_FETCH, 0, 0, 0), 1, res(0, 0, 0, 0, 0, 0)},
      '{mk(MODE_LOAD, 32'hffff_0000, 32'h0001_0000, 0), 0, '0},
      '{mk(MODE_LOAD, 0, 0, 32'h0000_8000), 0, '0},
      '{mk(MODE_FETCH, 0, 0, 0), 1, res(-16'sd32768, 16'sd32767, -16'sd8192, 1, 0, 0)},
      '{mk(MODE_FETCH, 0, 0, 0), 1, res(0, 0, 16'sd8192, 1, 1, 0)},
      '{mk(MODE_FETCH, 0, 0, 0), 1, res(0, 0, 0, 0, 0, 0)},
      '{mk(MODE_CLEAR, '1, '1, '1), 0, '0},
      '{mk(MODE_FETCH, 0, 0, 0), 1, res(0, 0, 0, 0, 0, 0)},
      '{mk(MODE_LOAD, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000), 0, '0},
      '{mk(MODE_LOAD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff), 0, '0},
      '{mk(MODE_LOAD, 0, 1, 32'hffff_ffff), 0, '0},
      '{mk(MODE_FETCH, 0, 0, 0), 1, res(-16'sd32768, 16'sd32767, -16'sd32768, 1, 0, 0)},
      '{mk(MODE_FETCH, 0, 0, 0), 0, '0},
      '{mk(MODE_LOAD, 32'h0123_4567, 32'h89ab_cdef, 32'h5555_aaaa), 0, '0},
      '{mk(MODE_FETCH, 0, 0, 0), 0, '0},
      '{mk(MODE_FETCH, 0, 0, 0), 0, '0},
      '{mk(MODE_FETCH, '1, '1, '1), 1, res(0, 0, 0, 0, 0, 0)},
      '{mk(MODE_CLEAR, 0, 0, 0), 0, '0}
    };
    shadow_count = 0;
    shadow_rd = 0;
    shadow_started = 1'b0;
    for (int a = 0; a < 3; a++) begin
      shadow_lo[a] = '0;
      shadow_hi[a] = '0;
    end
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].typed) send_checked(rows[i].stim, rows[i].want);
      else send_word(rows[i].stim);
    end
    drain_results();

    // Store-full case: fill all entries, try one more, read the first four back
    for (int i = 0; i < StoreDepth; i++)
      send_word(mk(MODE_LOAD, 32'(i) << 8, 32'(-i) <<< 4, 32'(i * 3)));
    send_word(mk(MODE_LOAD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    // skip ahead by fetching a handful, then clear
    for (int i = 0; i < 4; i++) send_word(mk(MODE_FETCH, 0, 0, 0));
    drain_results();
    send_word(mk(MODE_CLEAR, 0, 0, 0));

    // Back-pressure: receiver holds off while loads and fetches keep coming
    fork
      begin
        recv_hold = 1'b1;
        repeat (3000) @(negedge clk_i);
        recv_hold = 1'b0;
      end
      begin
        for (int i = 0; i < 6; i++) send_word(mk(MODE_LOAD, rand_coord(), rand_coord(),
                                                 rand_coord()));
        for (int i = 0; i < 10; i++) send_word(mk(MODE_FETCH, 0, 0, 0));
      end
    join
    drain_results();

    // Random phases with differing pacing
    sent = 0;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      phase_len = sent + 180;
      while (sent < phase_len) random_model(8, sent);
      // sender waits for everything outstanding at each phase end
      drain_results();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    drain_results();
    repeat (TailCycles) @(negedge clk_i);
    $display("Ran %0d random words plus directed and store-full checks;", sent);
    $display("saw %0d vertex fetches (%0d degenerate), %0d past-end fetches.",
             fetch_words, degen_words, past_end_words);
    if (fail_count == 0 && pending_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
